// File: sv/csirs_pkg.sv
// Shared types, constants and mapping-table lookups for the CSI-RS pattern generator.
// Depends on nothing; used by csirs_check, csirs_port and the top level.
`timescale 1ns / 1ps
`default_nettype none

package csirs_pkg;

	// Largest port count the block supports.
	localparam int MAX_PORTS = 16;

	// Subcarriers per PRB and symbols per slot.
	localparam int NRE  = 12;
	localparam int NSYM = 14;

	// Number of frequency reference inputs.
	localparam int NREFS = 6;

	// CDM type codes.
	localparam logic [1:0] CDM_NONE = 2'd0;
	localparam logic [1:0] CDM_FD2  = 2'd1;
	localparam logic [1:0] CDM_4    = 2'd2;
	localparam logic [1:0] CDM_8    = 2'd3;

	// Density codes.
	localparam logic [1:0] DENS_HALF_EVEN = 2'd0;
	localparam logic [1:0] DENS_HALF_ODD  = 2'd1;
	localparam logic [1:0] DENS_ONE       = 2'd2;
	localparam logic [1:0] DENS_THREE     = 2'd3;

	// Mapping table rows with a special layout.
	localparam logic [3:0] ROW_1  = 4'd1;
	localparam logic [3:0] ROW_4  = 4'd4;
	localparam logic [3:0] ROW_5  = 4'd5;
	localparam logic [3:0] ROW_6  = 4'd6;
	localparam logic [3:0] ROW_7  = 4'd7;
	localparam logic [3:0] ROW_8  = 4'd8;
	localparam logic [3:0] ROW_9  = 4'd9;
	localparam logic [3:0] ROW_10 = 4'd10;
	localparam logic [3:0] ROW_11 = 4'd11;
	localparam logic [3:0] ROW_12 = 4'd12;

	// Decoded request, held for the whole run of port results.
	typedef struct packed {
		logic                  bad;
		logic [3:0]            row;
		logic                  fspan2;
		logic                  tspan2;
		logic [NREFS-1:0][3:0] refs;
		logic [3:0]            l0;
		logic [3:0]            nports_m1;
		logic [8:0]            prb_begin;
		logic [9:0]            prb_end;
		logic [1:0]            prb_stride;
	} req_t;

	// One port result.
	typedef struct packed {
		logic [3:0]  port_number;
		logic [11:0] subcarrier_mask;
		logic [13:0] symbol_bits;
		logic [8:0]  prb_begin;
		logic [9:0]  prb_end;
		logic [1:0]  prb_stride;
		logic        bad_request;
		logic        last_port;
	} result_t;

	// Ports per row.
	function automatic logic [4:0] row_ports(input logic [3:0] row);
		logic [4:0] v;
		unique case (row)
			4'd1, 4'd2:         v = 5'd1;
			4'd3:               v = 5'd2;
			4'd4, 4'd5:         v = 5'd4;
			4'd6, 4'd7, 4'd8:   v = 5'd8;
			4'd9, 4'd10:        v = 5'd12;
			4'd11, 4'd12:       v = 5'd16;
			default:            v = 5'd0;
		endcase
		return v;
	endfunction

	// Reference subcarriers used by each row.
	function automatic logic [2:0] row_nrefs(input logic [3:0] row);
		logic [2:0] v;
		unique case (row)
			4'd1, 4'd2, 4'd3, 4'd4, 4'd5: v = 3'd1;
			4'd7, 4'd8:                   v = 3'd2;
			4'd10:                        v = 3'd3;
			4'd6, 4'd11, 4'd12:           v = 3'd4;
			4'd9:                         v = 3'd6;
			default:                      v = 3'd0;
		endcase
		return v;
	endfunction

	// CDM type each row requires.
	function automatic logic [1:0] row_cdm(input logic [3:0] row);
		logic [1:0] v;
		unique case (row)
			4'd8, 4'd10, 4'd12: v = CDM_4;
			4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd9, 4'd11: v = CDM_FD2;
			default:            v = CDM_NONE;
		endcase
		return v;
	endfunction

	// Allowed densities per row, bit d set when density code d is allowed.
	function automatic logic [3:0] row_dens(input logic [3:0] row);
		logic [3:0] v;
		unique case (row)
			4'd1:                      v = 4'b1000;
			4'd2, 4'd3, 4'd11, 4'd12:  v = 4'b0111;
			4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10: v = 4'b0100;
			default:                   v = 4'b0000;
		endcase
		return v;
	endfunction

	// Largest legal reference subcarrier per row.
	function automatic logic [3:0] row_kmax(input logic [3:0] row);
		logic [3:0] v;
		unique case (row)
			4'd1:    v = 4'd3;
			4'd2:    v = 4'd11;
			4'd4:    v = 4'd8;
			default: v = 4'd10;
		endcase
		return v;
	endfunction

	// Set for rows whose ports spread over two symbol positions.
	function automatic logic row_lext(input logic [3:0] row);
		logic v;
		unique case (row)
			4'd5, 4'd7, 4'd11: v = 1'b1;
			default:           v = 1'b0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: sv/csirs_check.sv
// Request checker and decoder: validates one resource description and builds req_t.
// Depends on csirs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csirs_check (
	input  wire logic [3:0]  table_row,
	input  wire logic [1:0]  cdm_kind,
	input  wire logic [1:0]  density_kind,
	input  wire logic [8:0]  first_prb,
	input  wire logic [8:0]  prb_count,
	input  wire logic [3:0]  symbol_start,
	input  wire logic [3:0]  subcarrier_ref_0,
	input  wire logic [3:0]  subcarrier_ref_1,
	input  wire logic [3:0]  subcarrier_ref_2,
	input  wire logic [3:0]  subcarrier_ref_3,
	input  wire logic [3:0]  subcarrier_ref_4,
	input  wire logic [3:0]  subcarrier_ref_5,
	output csirs_pkg::req_t  req
);

	logic [csirs_pkg::NREFS-1:0][3:0] refs;
	logic [4:0] nports;
	logic [2:0] nrefs;
	logic [3:0] kmax;
	logic [3:0] dens_ok;
	logic       row_ok;
	logic       ref_bad;
	logic       tspan2;
	logic [4:0] l_last;
	logic       bad;

	assign refs = {subcarrier_ref_5, subcarrier_ref_4, subcarrier_ref_3,
		subcarrier_ref_2, subcarrier_ref_1, subcarrier_ref_0};

	assign nports  = csirs_pkg::row_ports(table_row);
	assign nrefs   = csirs_pkg::row_nrefs(table_row);
	assign kmax    = csirs_pkg::row_kmax(table_row);
	assign dens_ok = csirs_pkg::row_dens(table_row);
	assign row_ok  = (table_row >= 4'd1) && (table_row <= 4'd12);

	// Every reference the row uses must stay within its bound.
	always_comb begin
		ref_bad = 1'b0;
		for (int i = 0; i < csirs_pkg::NREFS; i++) begin
			if ((3'(i) < nrefs) && (refs[i] > kmax))
				ref_bad = 1'b1;
		end
	end

	// The last symbol any port touches must fall inside the slot.
	assign tspan2 = (cdm_kind == csirs_pkg::CDM_4);
	assign l_last = {1'b0, symbol_start} + {4'd0, csirs_pkg::row_lext(table_row)}
		+ {4'd0, tspan2};

	assign bad = !row_ok
		|| (cdm_kind != csirs_pkg::row_cdm(table_row))
		|| !dens_ok[density_kind]
		|| ({1'b0, nports} > 6'(csirs_pkg::MAX_PORTS))
		|| ref_bad
		|| (l_last > 5'(csirs_pkg::NSYM - 1));

	// Assemble the decoded request, with the PRB range worked out once.
	always_comb begin
		req.bad        = bad;
		req.row        = table_row;
		req.fspan2     = (cdm_kind != csirs_pkg::CDM_NONE);
		req.tspan2     = tspan2;
		req.refs       = refs;
		req.l0         = symbol_start;
		req.nports_m1  = bad ? 4'd0 : 4'(nports - 5'd1);
		req.prb_end    = {1'b0, first_prb} + {1'b0, prb_count};
		req.prb_begin  = first_prb;
		req.prb_stride = 2'd1;
		if ((density_kind == csirs_pkg::DENS_HALF_EVEN)
				|| (density_kind == csirs_pkg::DENS_HALF_ODD)) begin
			req.prb_stride = 2'd2;
			if (first_prb[0] != density_kind[0])
				req.prb_begin = first_prb + 9'd1;
		end
	end

endmodule

`default_nettype wire

// File: sv/csirs_port.sv
// Port mapper: forms the resource element masks of one port of a decoded request.
// Depends on csirs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csirs_port (
	input  wire csirs_pkg::req_t    req,
	input  wire logic [3:0]         port,
	output csirs_pkg::result_t      res
);

	logic [2:0]  g;
	logic [3:0]  k;
	logic [3:0]  l;
	logic [11:0] sc;
	logic [13:0] sy;

	assign g = port[3:1];

	// Reference subcarrier and first symbol of this port's CDM group.
	always_comb begin
		k = req.refs[0];
		l = req.l0;
		unique case (req.row)
			csirs_pkg::ROW_4: k = req.refs[0] + {2'd0, g[0], 1'b0};
			csirs_pkg::ROW_5: l = req.l0 + {3'd0, g[0]};
			csirs_pkg::ROW_6, csirs_pkg::ROW_9: begin
				if (g < 3'(csirs_pkg::NREFS))
					k = req.refs[g];
			end
			csirs_pkg::ROW_7: begin
				k = req.refs[{2'd0, g[0]}];
				l = req.l0 + {3'd0, g[1]};
			end
			csirs_pkg::ROW_8, csirs_pkg::ROW_10, csirs_pkg::ROW_12:
				k = req.refs[{1'b0, port[3:2]}];
			csirs_pkg::ROW_11: begin
				k = req.refs[{1'b0, g[1:0]}];
				l = req.l0 + {3'd0, g[2]};
			end
			default: ;
		endcase
	end

	// Row 1 repeats its subcarrier every four; other rows cover the CDM span.
	always_comb begin
		if (req.row == csirs_pkg::ROW_1)
			sc = (12'h001 << k) | (12'h010 << k) | (12'h100 << k);
		else
			sc = (req.fspan2 ? 12'h003 : 12'h001) << k;
		sy = (req.tspan2 ? 14'h0003 : 14'h0001) << l;
	end

	// A rejected request yields a single flagged result.
	always_comb begin
		if (req.bad) begin
			res.port_number     = 4'd0;
			res.subcarrier_mask = 12'd0;
			res.symbol_bits     = 14'd0;
			res.prb_begin       = 9'd0;
			res.prb_end         = 10'd0;
			res.prb_stride      = 2'd1;
			res.bad_request     = 1'b1;
			res.last_port       = 1'b1;
		end else begin
			res.port_number     = port;
			res.subcarrier_mask = sc;
			res.symbol_bits     = sy;
			res.prb_begin       = req.prb_begin;
			res.prb_end         = req.prb_end;
			res.prb_stride      = req.prb_stride;
			res.bad_request     = 1'b0;
			res.last_port       = (port == req.nports_m1);
		end
	end

endmodule

`default_nettype wire

// File: sv/csi_rs_re_pattern_generator.sv
// CSI-RS resource element pattern generator top level: request register, port counter,
// result register. Depends on csirs_pkg, csirs_check and csirs_port.
//
//   channel   direction   handshake              payload
//   request   in          in_valid / in_stall    table_row .. subcarrier_ref_5
//   result    out         out_valid / out_stall  port_number .. last_port
//
// A request is checked and decoded as it is taken into the request register.
// One port result per cycle, while the output is not stalled, then goes to the result
// register, stepped by the port counter: one per port (1 to 16), or one if rejected.
// The next request is taken in the cycle its predecessor's last port leaves.
// Output stalls hold the result register and, through it, the port counter.
// Reset clears the request and result valid flags and the port counter.
`timescale 1ns / 1ps
`default_nettype none

module csi_rs_re_pattern_generator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  table_row,
	input  wire logic [1:0]  cdm_kind,
	input  wire logic [1:0]  density_kind,
	input  wire logic [8:0]  first_prb,
	input  wire logic [8:0]  prb_count,
	input  wire logic [3:0]  symbol_start,
	input  wire logic [3:0]  subcarrier_ref_0,
	input  wire logic [3:0]  subcarrier_ref_1,
	input  wire logic [3:0]  subcarrier_ref_2,
	input  wire logic [3:0]  subcarrier_ref_3,
	input  wire logic [3:0]  subcarrier_ref_4,
	input  wire logic [3:0]  subcarrier_ref_5,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       port_number,
	output logic [11:0]      subcarrier_mask,
	output logic [13:0]      symbol_bits,
	output logic [8:0]       prb_begin,
	output logic [9:0]       prb_end,
	output logic [1:0]       prb_stride,
	output logic             bad_request,
	output logic             last_port
);

	csirs_pkg::req_t    req_in;
	csirs_pkg::req_t    req_s1;
	logic               valid_s1;
	logic [3:0]         port_cnt_q;
	csirs_pkg::result_t res;
	csirs_pkg::result_t res_q;
	logic               out_valid_q;
	logic               advance;
	logic               take;
	logic               done;
	logic               in_xfer;

	csirs_check u_check (
		.table_row        (table_row),
		.cdm_kind         (cdm_kind),
		.density_kind     (density_kind),
		.first_prb        (first_prb),
		.prb_count        (prb_count),
		.symbol_start     (symbol_start),
		.subcarrier_ref_0 (subcarrier_ref_0),
		.subcarrier_ref_1 (subcarrier_ref_1),
		.subcarrier_ref_2 (subcarrier_ref_2),
		.subcarrier_ref_3 (subcarrier_ref_3),
		.subcarrier_ref_4 (subcarrier_ref_4),
		.subcarrier_ref_5 (subcarrier_ref_5),
		.req              (req_in)
	);

	csirs_port u_port (
		.req  (req_s1),
		.port (port_cnt_q),
		.res  (res)
	);

	// Handshake: the result register moves when empty or not stalled.
	assign advance  = !out_valid_q || !out_stall;
	assign take     = valid_s1 && advance;
	assign done     = take && res.last_port;
	assign in_stall = valid_s1 && !done;
	assign in_xfer  = in_valid && !in_stall;

	// Request register and port counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			port_cnt_q <= 4'd0;
		end else begin
			if (in_xfer)
				valid_s1 <= 1'b1;
			else if (done)
				valid_s1 <= 1'b0;
			if (done)
				port_cnt_q <= 4'd0;
			else if (take)
				port_cnt_q <= port_cnt_q + 4'd1;
		end
	end

	// Request payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_xfer)
			req_s1 <= req_in;
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (take)
			res_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign port_number     = res_q.port_number;
	assign subcarrier_mask = res_q.subcarrier_mask;
	assign symbol_bits     = res_q.symbol_bits;
	assign prb_begin       = res_q.prb_begin;
	assign prb_end         = res_q.prb_end;
	assign prb_stride      = res_q.prb_stride;
	assign bad_request     = res_q.bad_request;
	assign last_port       = res_q.last_port;

endmodule

`default_nettype wire

// File: sv/csirs_checker.sv
// Port-level checker for the CSI-RS pattern generator, bound to the top level.
// Depends on csi_rs_re_pattern_generator's port list only.
`timescale 1ns / 1ps
`default_nettype none

module csirs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [3:0]  port_number,
	input wire logic [11:0] subcarrier_mask,
	input wire logic        bad_request,
	input wire logic        last_port
);

	// A rejected request is one lone result at port zero with no resource elements.
	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_request |-> last_port && (port_number == 4'd0)
			&& (subcarrier_mask == 12'd0))
		else $error("rejected request result is malformed");

	// Ports of one request follow each other without gaps.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_port |=> out_valid)
		else $error("gap inside a run of port results");

	// Port numbers count up by one within a request.
	a_port_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_port |=>
			port_number == $past(port_number) + 4'd1)
		else $error("port number did not advance by one");

	// A stalled result is held.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(port_number)
			&& $stable(last_port))
		else $error("stalled result changed");

endmodule

bind csi_rs_re_pattern_generator csirs_checker u_csirs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.port_number     (port_number),
	.subcarrier_mask (subcarrier_mask),
	.bad_request     (bad_request),
	.last_port       (last_port)
);

`default_nettype wire
